// File: design/tci_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the thermistor curve interpolator.
// Holds the curve ROM, per-code span and limits, status codes and the
// controller/datapath command and status structs. No dependencies.
package tci_pkg;

  localparam int SEGMENTS   = 16;
  localparam int NUM_CODES  = 10;
  localparam int NUM_CURVES = 5;

  localparam int CODE_W  = 4;
  localparam int ADC_W   = 10;
  localparam int TEMP_W  = 20;
  localparam int STAT_W  = 2;
  localparam int SEG_W   = 4;   // segment index, 0..SEGMENTS-1
  localparam int IDX_W   = 5;   // curve point index, 0..SEGMENTS
  localparam int CURVE_W = 3;
  localparam int QUOT_W  = 7;   // in-segment fraction, 0..100
  localparam int NUM_W   = 17;  // (e[i]-adc)*100 up to 102300
  localparam int WORK_W  = 11;  // fraction + 100*segment, up to 1600
  localparam int SPAN_W  = 15;
  localparam int PROD_W  = 26;  // span * work
  localparam int SCL_W   = 19;  // span * work / 100, up to 342000
  localparam int CNT_W   = 3;

  // floor(x/100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^30
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 33;
  localparam logic [RECIP_W-1:0] RECIP_100 = 27'd85899346;

  typedef enum logic [STAT_W-1:0] {
    STS_INTERP = 2'd0,
    STS_LOW    = 2'd1,
    STS_HIGH   = 2'd2
  } status_t;

  localparam logic [ADC_W-1:0] CURVE_ROM [NUM_CURVES][SEGMENTS+1] = '{
    '{10'd932, 10'd844, 10'd716, 10'd564, 10'd412, 10'd284, 10'd192, 10'd128, 10'd84,
      10'd56, 10'd40, 10'd28, 10'd20, 10'd16, 10'd12, 10'd8, 10'd4},
    '{10'd988, 10'd964, 10'd924, 10'd862, 10'd778, 10'd682, 10'd572, 10'd462, 10'd364,
      10'd282, 10'd214, 10'd164, 10'd128, 10'd100, 10'd76, 10'd62, 10'd48},
    '{10'd932, 10'd860, 10'd760, 10'd640, 10'd508, 10'd384, 10'd280, 10'd200, 10'd140,
      10'd100, 10'd72, 10'd52, 10'd36, 10'd28, 10'd20, 10'd16, 10'd12},
    '{10'd976, 10'd948, 10'd906, 10'd842, 10'd764, 10'd670, 10'd566, 10'd466, 10'd376,
      10'd296, 10'd234, 10'd180, 10'd144, 10'd114, 10'd90, 10'd76, 10'd60},
    '{10'd984, 10'd952, 10'd908, 10'd844, 10'd764, 10'd668, 10'd564, 10'd460, 10'd368,
      10'd288, 10'd220, 10'd168, 10'd132, 10'd100, 10'd76, 10'd60, 10'd48}
  };

  localparam logic [SPAN_W-1:0] CODE_SPAN [NUM_CODES] = '{
    15'd11875, 15'd21375, 15'd10000, 15'd18000, 15'd10000,
    15'd18000, 15'd10000, 15'd18000, 15'd10000, 15'd18000
  };

  localparam logic signed [TEMP_W-1:0] CODE_LOW [NUM_CODES] = '{
    -20'sd40000, -20'sd40000, -20'sd40000, -20'sd40000, -20'sd40000,
    -20'sd40000, -20'sd40000, -20'sd40000, -20'sd50000, -20'sd58000
  };

  localparam logic signed [TEMP_W-1:0] CODE_HIGH [NUM_CODES] = '{
    20'sd150000, 20'sd302000, 20'sd120000, 20'sd248000, 20'sd120000,
    20'sd248000, 20'sd120000, 20'sd248000, 20'sd110000, 20'sd230000
  };

  function automatic logic [ADC_W-1:0] curve_entry(input logic [CURVE_W-1:0] curve,
                                                   input logic [IDX_W-1:0]   idx);
    return CURVE_ROM[curve][idx];
  endfunction

  typedef struct packed {
    logic              load_in;
    logic              check;
    logic              search;
    logic              dsetup;
    logic              div;
    logic              mul1;
    logic              mul2;
    logic              add;
    logic              load_out;
    logic [CNT_W-1:0]  bitpos;
  } dp_cmd_t;

  typedef struct packed {
    logic clamp;
  } dp_sts_t;

endpackage

// File: design/tci_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the thermistor curve interpolator.
// Depends on tci_pkg for field widths.
interface tci_in_if;
  logic                        valid;
  logic                        ready;
  logic [tci_pkg::CODE_W-1:0]  sensor_code;
  logic [tci_pkg::ADC_W-1:0]   adc_code;

  modport source (output valid, output sensor_code, output adc_code, input ready);
  modport sink   (input valid, input sensor_code, input adc_code, output ready);
endinterface

interface tci_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tci_pkg::TEMP_W-1:0] temperature;
  logic [tci_pkg::STAT_W-1:0]        status;

  modport source (output valid, output temperature, output status, input ready);
  modport sink   (input valid, input temperature, input status, output ready);
endinterface

// File: design/tci_datapath.sv
`timescale 1ns / 1ps
// Datapath: input latch, limit check, binary segment search, serial
// fraction divider, span scaling and the result register. Uses tci_pkg.
module tci_datapath (
  input  logic                              clk,
  input  tci_pkg::dp_cmd_t                  cmd,
  output tci_pkg::dp_sts_t                  sts,
  input  logic [tci_pkg::CODE_W-1:0]        in_sensor_code,
  input  logic [tci_pkg::ADC_W-1:0]         in_adc_code,
  output logic signed [tci_pkg::TEMP_W-1:0] out_temperature,
  output logic [tci_pkg::STAT_W-1:0]        out_status
);

  logic [tci_pkg::CODE_W-1:0]        sel_r;
  logic [tci_pkg::ADC_W-1:0]         adc_r;
  logic [tci_pkg::SEG_W-1:0]         seg_r;
  logic [tci_pkg::ADC_W-1:0]         den_r;
  logic [tci_pkg::NUM_W-1:0]         rem_r;
  logic [tci_pkg::QUOT_W-1:0]        q_r;
  logic [tci_pkg::PROD_W-1:0]        prod_r;
  logic [tci_pkg::SCL_W-1:0]         scl_r;
  logic signed [tci_pkg::TEMP_W-1:0] res_temp_r;
  logic [tci_pkg::STAT_W-1:0]        res_status_r;
  logic signed [tci_pkg::TEMP_W-1:0] out_temp_r;
  logic [tci_pkg::STAT_W-1:0]        out_status_r;

  logic [tci_pkg::CODE_W-1:0]  sel_nxt;
  logic [tci_pkg::CURVE_W-1:0] curve;
  logic [tci_pkg::ADC_W-1:0]   e_first, e_last, e_cand, e_hi, e_lo;
  logic [tci_pkg::SEG_W-1:0]   cand;
  logic                        at_high, at_low;
  logic [tci_pkg::NUM_W-1:0]   dsh;
  logic [tci_pkg::WORK_W-1:0]  work;
  logic [tci_pkg::PROD_W+tci_pkg::RECIP_W-1:0] prod2;

  // Saturate the code into 1..10, then keep it zero-based
  always_comb begin
    if (in_sensor_code == '0) begin
      sel_nxt = '0;
    end else if (in_sensor_code > tci_pkg::CODE_W'(tci_pkg::NUM_CODES)) begin
      sel_nxt = tci_pkg::CODE_W'(tci_pkg::NUM_CODES - 1);
    end else begin
      sel_nxt = in_sensor_code - 1'b1;
    end
  end

  assign curve   = sel_r[tci_pkg::CODE_W-1:1];
  assign e_first = tci_pkg::curve_entry(curve, '0);
  assign e_last  = tci_pkg::curve_entry(curve, tci_pkg::IDX_W'(tci_pkg::SEGMENTS));
  assign cand    = seg_r | (tci_pkg::SEG_W'(1) << cmd.bitpos[1:0]);
  assign e_cand  = tci_pkg::curve_entry(curve, tci_pkg::IDX_W'(cand));
  assign e_hi    = tci_pkg::curve_entry(curve, tci_pkg::IDX_W'(seg_r));
  assign e_lo    = tci_pkg::curve_entry(curve, tci_pkg::IDX_W'(seg_r) + 1'b1);

  assign at_high   = adc_r <= e_last;
  assign at_low    = adc_r >= e_first;
  assign sts.clamp = at_high || at_low;

  assign dsh   = tci_pkg::NUM_W'(den_r) << cmd.bitpos;
  assign work  = tci_pkg::WORK_W'(q_r) + tci_pkg::WORK_W'(seg_r) * tci_pkg::WORK_W'(100);
  assign prod2 = (tci_pkg::PROD_W+tci_pkg::RECIP_W)'(prod_r)
               * (tci_pkg::PROD_W+tci_pkg::RECIP_W)'(tci_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sel_r <= sel_nxt;
      adc_r <= in_adc_code;
    end
    if (cmd.check) begin
      seg_r <= '0;
      if (at_high) begin
        res_temp_r   <= tci_pkg::CODE_HIGH[sel_r];
        res_status_r <= tci_pkg::STS_HIGH;
      end else begin
        res_temp_r   <= tci_pkg::CODE_LOW[sel_r];
        res_status_r <= at_low ? tci_pkg::STS_LOW : tci_pkg::STS_INTERP;
      end
    end
    // Keep the largest index whose point still lies above the reading
    if (cmd.search && (adc_r < e_cand)) begin
      seg_r <= cand;
    end
    if (cmd.dsetup) begin
      den_r <= e_hi - e_lo;
      rem_r <= tci_pkg::NUM_W'(e_hi - adc_r) * tci_pkg::NUM_W'(100);
      q_r   <= '0;
    end
    // Restoring division, one quotient bit per cycle from the top
    if (cmd.div && (rem_r >= dsh)) begin
      rem_r           <= rem_r - dsh;
      q_r[cmd.bitpos] <= 1'b1;
    end
    if (cmd.mul1) begin
      prod_r <= tci_pkg::PROD_W'(tci_pkg::CODE_SPAN[sel_r]) * tci_pkg::PROD_W'(work);
    end
    if (cmd.mul2) begin
      scl_r <= prod2[tci_pkg::RECIP_SHIFT +: tci_pkg::SCL_W];
    end
    if (cmd.add) begin
      res_temp_r <= $signed({1'b0, scl_r}) + tci_pkg::CODE_LOW[sel_r];
    end
    if (cmd.load_out) begin
      out_temp_r   <= res_temp_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_temperature = out_temp_r;
  assign out_status      = out_status_r;

endmodule

// File: design/tci_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences check, search, division and scaling steps and
// owns the input ready and output valid flags. Uses tci_pkg.
module tci_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tci_pkg::dp_sts_t sts,
  output tci_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_DSETUP,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_ADD,
    ST_FINISH
  } state_t;

  state_t                    state_r;
  logic [tci_pkg::CNT_W-1:0] cnt_r;
  logic                      out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state_r == ST_IDLE) && in_valid;
    cmd.check    = state_r == ST_CHECK;
    cmd.search   = state_r == ST_SEARCH;
    cmd.dsetup   = state_r == ST_DSETUP;
    cmd.div      = state_r == ST_DIV;
    cmd.mul1     = state_r == ST_MUL1;
    cmd.mul2     = state_r == ST_MUL2;
    cmd.add      = state_r == ST_ADD;
    cmd.load_out = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
    cmd.bitpos   = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (sts.clamp) begin
            state_r <= ST_FINISH;
          end else begin
            state_r <= ST_SEARCH;
            cnt_r   <= tci_pkg::CNT_W'(tci_pkg::SEG_W - 1);
          end
        end
        ST_SEARCH: begin
          if (cnt_r == '0) begin
            state_r <= ST_DSETUP;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_DSETUP: begin
          state_r <= ST_DIV;
          cnt_r   <= tci_pkg::CNT_W'(tci_pkg::QUOT_W - 1);
        end
        ST_DIV: begin
          if (cnt_r == '0) begin
            state_r <= ST_MUL1;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_MUL1:   state_r <= ST_MUL2;
        ST_MUL2:   state_r <= ST_ADD;
        ST_ADD:    state_r <= ST_FINISH;
        ST_FINISH: begin
          // hold the result until the output register is free
          if (cmd.load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

// File: design/thermistor_curve_interpolator_top.sv
`timescale 1ns / 1ps
// Thermistor curve interpolator: ADC code plus sensor code to milli-degrees.
// Steps per item: an interpolated item goes through 1 check, 4 search
// steps, 1 setup, 7 divider steps, 2 multiplies, 1 add and 1 output load;
// an item clamped to a limit goes from the check to the output load.
// One item at a time: a new item is taken only once the last result is
// loaded for output, later while a waiting result is held off by the output.
// Reset (synchronous, rst_n low) returns the controller to idle, output empty.
module thermistor_curve_interpolator_top (
  input logic       clk,
  input logic       rst_n,
  tci_in_if.sink    in_ch,
  tci_out_if.source out_ch
);

  tci_pkg::dp_cmd_t dp_cmd;
  tci_pkg::dp_sts_t dp_sts;

  tci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  tci_datapath u_dp (
    .clk             (clk),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_sensor_code  (in_ch.sensor_code),
    .in_adc_code     (in_ch.adc_code),
    .out_temperature (out_ch.temperature),
    .out_status      (out_ch.status)
  );

  // one item in flight: no transfer on the cycle after a transfer
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load_out |=> out_ch.valid)
    else $error("result loaded but output not valid");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.check, dp_cmd.search, dp_cmd.dsetup, dp_cmd.div,
              dp_cmd.mul1, dp_cmd.mul2, dp_cmd.add, dp_cmd.load_out}))
    else $error("more than one datapath step commanded");

endmodule

// File: bench/tb_thermistor_curve_interpolator_top.sv
`timescale 1ns / 1ps
// Testbench for the thermistor curve interpolator: drives readings through the
// input channel and checks each temperature/status against a local predictor.
// Depends on tci_pkg, tci_if and thermistor_curve_interpolator_top.
module tb_thermistor_curve_interpolator_top;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_OFF_LONG  = 300;
  localparam int PT_LAST        = 16;

  // Descending calibration points, one row per curve.
  localparam int PT_TABLE [5][17] = '{
    '{932, 844, 716, 564, 412, 284, 192, 128, 84, 56, 40, 28, 20, 16, 12, 8, 4},
    '{988, 964, 924, 862, 778, 682, 572, 462, 364, 282, 214, 164, 128, 100, 76, 62, 48},
    '{932, 860, 760, 640, 508, 384, 280, 200, 140, 100, 72, 52, 36, 28, 20, 16, 12},
    '{976, 948, 906, 842, 764, 670, 566, 466, 376, 296, 234, 180, 144, 114, 90, 76, 60},
    '{984, 952, 908, 844, 764, 668, 564, 460, 368, 288, 220, 168, 132, 100, 76, 60, 48}
  };
  localparam int SPAN_TABLE [10] = '{
    11875, 21375, 10000, 18000, 10000, 18000, 10000, 18000, 10000, 18000
  };
  localparam int LOW_LIMIT [10] = '{
    -40000, -40000, -40000, -40000, -40000, -40000, -40000, -40000, -50000, -58000
  };
  localparam int HIGH_LIMIT [10] = '{
    150000, 302000, 120000, 248000, 120000, 248000, 120000, 248000, 110000, 230000
  };

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic signed [tci_pkg::TEMP_W-1:0] temperature;
    tci_pkg::status_t                  status;
  } reading_t;

  logic clk;
  logic rst_n;

  tci_in_if  in_ch ();
  tci_out_if out_ch ();

  thermistor_curve_interpolator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  reading_t expected_readings [$];
  int       mismatches;
  int       tx_gap_max;
  int       burst_left;
  rx_mode_t rx_mode;
  int       hold_off_left;
  int       rx_tick;
  int       idle_cycles;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Table row for a sensor code; codes outside 1..10 saturate.
  function automatic int code_to_sel(input logic [tci_pkg::CODE_W-1:0] code);
    if (code == 0) begin
      return 0;
    end
    if (code > 10) begin
      return 9;
    end
    return int'(code) - 1;
  endfunction

  function automatic reading_t predict_reading(input logic [tci_pkg::CODE_W-1:0] code,
                                               input logic [tci_pkg::ADC_W-1:0]  adc);
    reading_t r;
    int sel, crv, a, seg, hi, lo, frac, scaled;
    sel = code_to_sel(code);
    crv = sel >> 1;
    a   = int'(adc);
    if (a <= PT_TABLE[crv][PT_LAST]) begin
      r.temperature = tci_pkg::TEMP_W'(HIGH_LIMIT[sel]);
      r.status      = tci_pkg::STS_HIGH;
    end else if (a >= PT_TABLE[crv][0]) begin
      r.temperature = tci_pkg::TEMP_W'(LOW_LIMIT[sel]);
      r.status      = tci_pkg::STS_LOW;
    end else begin
      seg = 0;
      while (seg + 1 < PT_LAST && a < PT_TABLE[crv][seg+1]) seg++;
      hi     = PT_TABLE[crv][seg];
      lo     = PT_TABLE[crv][seg+1];
      frac   = (hi - a) * 100 / (hi - lo) + seg * 100;
      scaled = SPAN_TABLE[sel] * frac / 100;
      r.temperature = tci_pkg::TEMP_W'(scaled + LOW_LIMIT[sel]);
      r.status      = tci_pkg::STS_INTERP;
    end
    return r;
  endfunction

  // Offer one reading and hold it until the transfer; then maybe end the burst.
  task automatic send_reading(input logic [tci_pkg::CODE_W-1:0] code,
                              input logic [tci_pkg::ADC_W-1:0]  adc);
    in_ch.valid       <= 1'b1;
    in_ch.sensor_code <= code;
    in_ch.adc_code    <= adc;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_readings.push_back(predict_reading(code, adc));
    if (tx_gap_max > 0) begin
      if (burst_left <= 1) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(tx_gap_max, 1)) @(posedge clk);
        burst_left = $urandom_range(8, 1);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    wait (expected_readings.size() == 0);
    @(posedge clk);
  endtask

  task automatic random_reading(output logic [tci_pkg::CODE_W-1:0] code,
                                output logic [tci_pkg::ADC_W-1:0]  adc);
    int crv, kind, a;
    code = ($urandom_range(99) < 88) ? tci_pkg::CODE_W'($urandom_range(10, 1))
                                     : tci_pkg::CODE_W'($urandom_range(15, 0));
    crv  = code_to_sel(code) >> 1;
    kind = $urandom_range(99);
    if (kind < 55) begin
      a = $urandom_range(PT_TABLE[crv][0] - 1, PT_TABLE[crv][PT_LAST] + 1);
    end else if (kind < 75) begin
      a = PT_TABLE[crv][$urandom_range(PT_LAST)] + $urandom_range(2) - 1;
    end else begin
      a = $urandom_range(1023);
    end
    if (a < 0) a = 0;
    if (a > 1023) a = 1023;
    adc = tci_pkg::ADC_W'(a);
  endtask

  task automatic test_limit_clamps();
    tx_gap_max = 3;
    rx_mode    = RX_RANDOM;
    for (int c = 0; c < 5; c++) begin
      send_reading(tci_pkg::CODE_W'(2 * c + 1), tci_pkg::ADC_W'(PT_TABLE[c][0]));
      send_reading(tci_pkg::CODE_W'(2 * c + 2), tci_pkg::ADC_W'(PT_TABLE[c][PT_LAST]));
    end
    send_reading(tci_pkg::CODE_W'(2), tci_pkg::ADC_W'(0));
    send_reading(tci_pkg::CODE_W'(9), tci_pkg::ADC_W'(1023));
    wait_drained();
  endtask

  task automatic test_code_saturation();
    tx_gap_max = 0;
    rx_mode    = RX_ALWAYS;
    send_reading(tci_pkg::CODE_W'(0), tci_pkg::ADC_W'(500));
    send_reading(tci_pkg::CODE_W'(11), tci_pkg::ADC_W'(500));
    send_reading(tci_pkg::CODE_W'(15), tci_pkg::ADC_W'(200));
    send_reading(tci_pkg::CODE_W'(15), tci_pkg::ADC_W'(1023));
    wait_drained();
  endtask

  task automatic test_segment_edges();
    tx_gap_max = 20;
    rx_mode    = RX_PATTERN;
    // last segment, just above the final point
    send_reading(tci_pkg::CODE_W'(1), tci_pkg::ADC_W'(PT_TABLE[0][PT_LAST] + 1));
    send_reading(tci_pkg::CODE_W'(10), tci_pkg::ADC_W'(PT_TABLE[4][PT_LAST] + 1));
    // first segment, just below the first point
    send_reading(tci_pkg::CODE_W'(5), tci_pkg::ADC_W'(PT_TABLE[2][0] - 1));
    // exactly on inner points, then just above one
    send_reading(tci_pkg::CODE_W'(7), tci_pkg::ADC_W'(PT_TABLE[3][8]));
    send_reading(tci_pkg::CODE_W'(4), tci_pkg::ADC_W'(PT_TABLE[1][15]));
    send_reading(tci_pkg::CODE_W'(8), tci_pkg::ADC_W'(PT_TABLE[3][7] + 1));
    wait_drained();
  endtask

  task automatic test_random_readings(input int count, input int gap_max,
                                      input rx_mode_t mode);
    logic [tci_pkg::CODE_W-1:0] code;
    logic [tci_pkg::ADC_W-1:0]  adc;
    tx_gap_max = gap_max;
    rx_mode    = mode;
    burst_left = $urandom_range(8, 1);
    repeat (count) begin
      random_reading(code, adc);
      send_reading(code, adc);
    end
    wait_drained();
  endtask

  // Starve the output for a long stretch while the input keeps offering.
  task automatic test_output_backpressure();
    logic [tci_pkg::CODE_W-1:0] code;
    logic [tci_pkg::ADC_W-1:0]  adc;
    tx_gap_max    = 0;
    rx_mode       = RX_ALWAYS;
    hold_off_left = HOLD_OFF_LONG;
    repeat (30) begin
      random_reading(code, adc);
      send_reading(code, adc);
    end
    wait_drained();
  endtask

  // Receiver: long hold-off first, otherwise the selected stall pattern.
  initial begin
    logic ready_next;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_off_left > 0) begin
        hold_off_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  ready_next = 1'b1;
          RX_RANDOM:  ready_next = ($urandom_range(99) < 70);
          default:    ready_next = ((rx_tick % 23) < 15);
        endcase
      end
      out_ch.ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result temperature %0d status %0d", $time,
                 out_ch.temperature, out_ch.status);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (out_ch.temperature !== want.temperature) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   want.temperature, out_ch.temperature);
          mismatches++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_ch.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("[thermistor_curve_interpolator_top] ERROR");
      $finish;
    end
  end

  initial begin
    mismatches    = 0;
    tx_gap_max    = 0;
    burst_left    = 1;
    rx_mode       = RX_ALWAYS;
    hold_off_left = 0;
    rx_tick       = 0;
    idle_cycles   = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.sensor_code <= '0;
    in_ch.adc_code    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_limit_clamps();
    test_code_saturation();
    test_segment_edges();
    test_random_readings(300, 0, RX_ALWAYS);
    test_random_readings(280, 25, RX_RANDOM);
    test_random_readings(280, 4, RX_PATTERN);
    test_output_backpressure();
    test_random_readings(280, 0, RX_RANDOM);
    test_random_readings(280, 25, RX_ALWAYS);
    test_random_readings(280, 10, RX_PATTERN);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[thermistor_curve_interpolator_top] OK");
    end else begin
      $display("[thermistor_curve_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tci_pkg.sv
design/tci_if.sv
design/tci_datapath.sv
design/tci_ctrl.sv
design/thermistor_curve_interpolator_top.sv
bench/tb_thermistor_curve_interpolator_top.sv
